FILE: rtl/core/oct_pkg.sv
// Shared types, codes and constants of the ordered completion throttle.
package oct_pkg;

  localparam int unsigned WINDOW = 16;
  localparam int unsigned TAG_W  = 4;
  localparam int unsigned CODE_W = 13;
  localparam int unsigned CNT_W  = 5;

  typedef logic [TAG_W-1:0]         tag_t;
  typedef logic signed [CODE_W-1:0] code_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  localparam cnt_t  WINDOW_CNT     = cnt_t'(WINDOW);
  localparam cnt_t  MAX_IN_FLIGHT_RST = cnt_t'(16);
  localparam code_t NOT_FOUND_CODE = code_t'(-2);

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_FINISH = 2'd1,
    REQ_END    = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_BUSY = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic REG_MAX_IN_FLIGHT    = 1'b0;
  localparam logic REG_IGNORE_NOT_FOUND = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_EMIT  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_e;

  // Update requests from the sequencer to the window store.
  typedef struct packed {
    logic  open;
    tag_t  open_tag;
    logic  fin;
    tag_t  fin_tag;
    code_t fin_code;
    logic  pop;
    tag_t  head;
  } win_ctrl_t;

  // What the window store reports about the head of the window.
  typedef struct packed {
    logic  head_done;
    logic  next_done;
    code_t head_code;
  } win_stat_t;

endpackage

FILE: rtl/core/ordered_completion_throttle.sv
// Top level: in-order completion buffer with a limit on operations in flight.
//
// Items come in on the req channel (in_valid_i / in_stall_o): a start opens
// the next wrapping tag, a finish marks a tag done with its code, an end
// lowers the in-flight count and latches the first error code.
// Every item gives one status result on the out channel, then the done
// operations at the head of the window are released in tag order, one
// result per transfer; last_o marks the final result of the item.
// An item is accepted in the idle state; the update is made in S_EXEC,
// the status result is loaded in S_EMIT and each release in S_DRAIN.
// The sequencer walks the window head one entry per cycle while the out
// channel does not stall; a stall on the out channel holds the output
// register and the walk. The APB port sets max_in_flight (offset 0) and
// ignore_not_found (offset 4); the user must write it only while the block
// is idle, and the block itself does not enforce this.
// Reset empties the window, clears the counters and the latched error, and
// sets max_in_flight to 16 and ignore_not_found to 0.
module ordered_completion_throttle (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [3:0]         tag_i,
  input  logic signed [12:0] ret_code_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic [3:0]         out_tag_o,
  output logic signed [12:0] out_code_o,
  output logic [1:0]         status_o,
  output logic [4:0]         in_flight_o,
  output logic signed [12:0] first_error_o,
  output logic               all_done_o,
  output logic               last_o
);

  oct_pkg::state_e    state_q, state_d;
  oct_pkg::req_e      req_q;
  oct_pkg::tag_t      tag_q;
  oct_pkg::code_t     code_q;
  oct_pkg::tag_t      next_tag_q, next_tag_d;
  oct_pkg::tag_t      head_tag_q, head_tag_d;
  oct_pkg::cnt_t      in_flight_q, in_flight_d;
  oct_pkg::cnt_t      entry_count_q, entry_count_d;
  oct_pkg::code_t     first_error_q, first_error_d;
  oct_pkg::cnt_t      max_q;
  logic               ign_q;
  logic [1:0]         st_q, st_d;
  oct_pkg::tag_t      otag_q, otag_d;

  logic               out_valid_q;
  logic               kind_q, kind_d;
  oct_pkg::tag_t      out_tag_q, out_tag_d;
  oct_pkg::code_t     out_code_q, out_code_d;
  logic [1:0]         status_q, status_d;
  oct_pkg::cnt_t      out_in_flight_q;
  oct_pkg::code_t     out_error_q;
  logic               last_q, last_d;
  logic               out_load;
  logic               out_free;

  oct_pkg::win_ctrl_t win_ctrl;
  oct_pkg::win_stat_t win_stat;

  logic               in_accept;
  logic               cfg_write;
  logic               busy;
  oct_pkg::tag_t      off;
  logic               unknown_tag;
  logic               latch_ok;
  oct_pkg::cnt_t      count_less;

  oct_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .stat_o (win_stat)
  );

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (paddr[2] == oct_pkg::REG_MAX_IN_FLIGHT) begin
      prdata = {27'd0, max_q};
    end else begin
      prdata = {31'd0, ign_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= oct_pkg::MAX_IN_FLIGHT_RST;
      ign_q <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == oct_pkg::REG_MAX_IN_FLIGHT) begin
        max_q <= pwdata[4:0];
      end else begin
        ign_q <= pwdata[0];
      end
    end
  end

  assign in_stall_o = (state_q != oct_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Item checks, evaluated in the update cycle.
  assign busy        = (in_flight_q >= max_q) || (entry_count_q >= oct_pkg::WINDOW_CNT);
  assign off         = tag_q - head_tag_q;
  assign unknown_tag = ({1'b0, off} >= entry_count_q);
  assign latch_ok    = code_q[oct_pkg::CODE_W-1] && (first_error_q == '0) &&
                       ((code_q != oct_pkg::NOT_FOUND_CODE) || !ign_q);
  assign count_less  = entry_count_q - oct_pkg::cnt_t'(1);

  always_comb begin
    state_d       = state_q;
    next_tag_d    = next_tag_q;
    head_tag_d    = head_tag_q;
    in_flight_d   = in_flight_q;
    entry_count_d = entry_count_q;
    first_error_d = first_error_q;
    st_d          = st_q;
    otag_d        = otag_q;
    out_load      = 1'b0;
    kind_d        = oct_pkg::KIND_STATUS;
    out_tag_d     = otag_q;
    out_code_d    = '0;
    status_d      = st_q;
    last_d        = 1'b1;
    win_ctrl          = '0;
    win_ctrl.open_tag = next_tag_q;
    win_ctrl.fin_tag  = tag_q;
    win_ctrl.fin_code = code_q;
    win_ctrl.head     = head_tag_q;

    case (state_q)
      oct_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = oct_pkg::S_EXEC;
        end
      end
      oct_pkg::S_EXEC: begin
        st_d    = oct_pkg::STATUS_OK;
        otag_d  = '0;
        state_d = oct_pkg::S_EMIT;
        case (req_q)
          oct_pkg::REQ_START: begin
            if (busy) begin
              st_d = oct_pkg::STATUS_BUSY;
            end else begin
              otag_d        = next_tag_q;
              win_ctrl.open = 1'b1;
              next_tag_d    = next_tag_q + oct_pkg::tag_t'(1);
              entry_count_d = entry_count_q + oct_pkg::cnt_t'(1);
              in_flight_d   = in_flight_q + oct_pkg::cnt_t'(1);
            end
          end
          oct_pkg::REQ_FINISH: begin
            if (unknown_tag) begin
              st_d = oct_pkg::STATUS_BAD;
            end else begin
              win_ctrl.fin = 1'b1;
            end
          end
          oct_pkg::REQ_END: begin
            if (in_flight_q == '0) begin
              st_d = oct_pkg::STATUS_BAD;
            end else begin
              if (latch_ok) begin
                first_error_d = code_q;
              end
              in_flight_d = in_flight_q - oct_pkg::cnt_t'(1);
            end
          end
          default: begin
          end
        endcase
      end
      oct_pkg::S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          last_d   = (entry_count_q == '0) || !win_stat.head_done;
          state_d  = last_d ? oct_pkg::S_IDLE : oct_pkg::S_DRAIN;
        end
      end
      oct_pkg::S_DRAIN: begin
        if (out_free) begin
          out_load      = 1'b1;
          kind_d        = oct_pkg::KIND_RELEASE;
          out_tag_d     = head_tag_q;
          out_code_d    = win_stat.head_code;
          status_d      = oct_pkg::STATUS_OK;
          // The walk ends when the window empties or the next entry is open.
          last_d        = (count_less == '0) || !win_stat.next_done;
          win_ctrl.pop  = 1'b1;
          head_tag_d    = head_tag_q + oct_pkg::tag_t'(1);
          entry_count_d = count_less;
          state_d       = last_d ? oct_pkg::S_IDLE : oct_pkg::S_DRAIN;
        end
      end
      default: begin
        state_d = oct_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= oct_pkg::S_IDLE;
      next_tag_q    <= '0;
      head_tag_q    <= '0;
      in_flight_q   <= '0;
      entry_count_q <= '0;
      first_error_q <= '0;
      st_q          <= oct_pkg::STATUS_OK;
      otag_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      next_tag_q    <= next_tag_d;
      head_tag_q    <= head_tag_d;
      in_flight_q   <= in_flight_d;
      entry_count_q <= entry_count_d;
      first_error_q <= first_error_d;
      st_q          <= st_d;
      otag_q        <= otag_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q  <= oct_pkg::req_e'(req_type_i);
      tag_q  <= tag_i;
      code_q <= ret_code_i;
    end
    if (out_load) begin
      kind_q          <= kind_d;
      out_tag_q       <= out_tag_d;
      out_code_q      <= out_code_d;
      status_q        <= status_d;
      out_in_flight_q <= in_flight_q;
      out_error_q     <= first_error_q;
      last_q          <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign out_tag_o     = out_tag_q;
  assign out_code_o    = out_code_q;
  assign status_o      = status_q;
  assign in_flight_o   = out_in_flight_q;
  assign first_error_o = out_error_q;
  assign all_done_o    = (out_in_flight_q == '0);
  assign last_o        = last_q;

  // The open entries always span exactly the tags from head to next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q[3:0] == (next_tag_q - head_tag_q))
    else $error("window count disagrees with head and next tags");

  // The window never holds more entries than its size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q <= oct_pkg::WINDOW_CNT)
    else $error("entry count above window size");

  // A release only takes a done head entry from a non-empty window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == oct_pkg::S_DRAIN && out_free) |->
      (win_stat.head_done && entry_count_q != '0))
    else $error("release of an entry that is not done");

  // Once an error is latched it is never replaced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (first_error_q != '0) |=> $stable(first_error_q))
    else $error("latched error changed");

endmodule

FILE: rtl/core/oct_window.sv
// Window store: done flags and result codes of the open operations.
module oct_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  oct_pkg::win_ctrl_t ctrl_i,
  output oct_pkg::win_stat_t stat_o
);

  logic [oct_pkg::WINDOW-1:0] done_q;
  oct_pkg::code_t             code_q [oct_pkg::WINDOW];
  oct_pkg::tag_t              next_head;

  assign next_head = ctrl_i.head + oct_pkg::tag_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
    end else begin
      if (ctrl_i.open) begin
        done_q[ctrl_i.open_tag] <= 1'b0;
      end
      if (ctrl_i.fin) begin
        done_q[ctrl_i.fin_tag] <= 1'b1;
      end
      if (ctrl_i.pop) begin
        done_q[ctrl_i.head] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fin) begin
      code_q[ctrl_i.fin_tag] <= ctrl_i.fin_code;
    end
  end

  assign stat_o.head_done = done_q[ctrl_i.head];
  assign stat_o.next_done = done_q[next_head];
  assign stat_o.head_code = code_q[ctrl_i.head];

endmodule

FILE: dv/oct_completion_monitor.sv
// Watches the throttle's channels and register port, predicts every result and checks it.
module oct_completion_monitor
  import oct_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [1:0]        req_type_i,
  input  tag_t              tag_i,
  input  code_t             ret_code_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              kind_i,
  input  tag_t              out_tag_i,
  input  code_t             out_code_i,
  input  logic [1:0]        status_i,
  input  cnt_t              in_flight_i,
  input  code_t             first_error_i,
  input  logic              all_done_i,
  input  logic              last_i,
  output int                errors_o,
  output int                checked_o,
  output int                due_o,
  output tag_t              head_o,
  output int                open_o,
  output cnt_t              flight_o,
  output logic [WINDOW-1:0] done_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       kind;
    tag_t       tg;
    code_t      code;
    logic [1:0] st;
    cnt_t       flight;
    code_t      ferr;
    logic       idle;
    logic       last;
  } result_t;

  result_t due_results[$];

  // Shadow of the window, the counters and the two registers.
  tag_t              nxt_tag   = '0;
  tag_t              head_tag  = '0;
  int                open_cnt  = 0;
  cnt_t              flight    = '0;
  logic [WINDOW-1:0] done_m    = '0;
  code_t             code_m [WINDOW] = '{default: '0};
  code_t             err_latch = '0;
  cnt_t              limit     = MAX_IN_FLIGHT_RST;
  logic              skip_nf   = 1'b0;

  function automatic result_t make_result(logic kd, tag_t tg, code_t cd, logic [1:0] st);
    result_t r;
    r.kind   = kd;
    r.tg     = tg;
    r.code   = cd;
    r.st     = st;
    r.flight = flight;
    r.ferr   = err_latch;
    r.idle   = (flight == 0);
    r.last   = 1'b0;
    return r;
  endfunction

  // Applies one item to the shadow window and queues the status and the releases it causes.
  task automatic advance_window(req_e rq, tag_t tg, code_t cd);
    logic [1:0] st;
    tag_t       granted;
    tag_t       offset;
    result_t    held;
    st      = STATUS_OK;
    granted = '0;
    case (rq)
      REQ_START: begin
        if (flight >= limit || open_cnt >= WINDOW) begin
          st = STATUS_BUSY;
        end else begin
          granted         = nxt_tag;
          done_m[nxt_tag] = 1'b0;
          code_m[nxt_tag] = '0;
          nxt_tag++;
          open_cnt++;
          flight++;
        end
      end
      REQ_FINISH: begin
        offset = tg - head_tag;
        if (offset >= open_cnt) begin
          st = STATUS_BAD;
        end else begin
          done_m[tg] = 1'b1;
          code_m[tg] = cd;
        end
      end
      REQ_END: begin
        if (flight == 0) begin
          st = STATUS_BAD;
        end else begin
          if (cd < 0 && err_latch == 0 && (cd != NOT_FOUND_CODE || !skip_nf)) begin
            err_latch = cd;
          end
          flight--;
        end
      end
      default: ;
    endcase
    held = make_result(KIND_STATUS, granted, '0, st);
    for (int k = 0; k < WINDOW && open_cnt > 0 && done_m[head_tag]; k++) begin
      due_results.push_back(held);
      held             = make_result(KIND_RELEASE, head_tag, code_m[head_tag], STATUS_OK);
      done_m[head_tag] = 1'b0;
      head_tag++;
      open_cnt--;
    end
    held.last = 1'b1;
    due_results.push_back(held);
  endtask

  task automatic flag_field(string fld, logic signed [31:0] exp_v, logic signed [31:0] act_v);
    errors_o++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, exp_v, act_v);
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      errors_o++;
      $display("%0t: result with none expected: kind %0d tag %0d code %0d status %0d",
               $time, got.kind, got.tg, $signed(got.code), got.st);
    end else begin
      want = due_results.pop_front();
      checked_o++;
      if (got.kind !== want.kind)     flag_field("kind", want.kind, got.kind);
      if (got.tg !== want.tg)         flag_field("out_tag", want.tg, got.tg);
      if (got.code !== want.code)
        flag_field("out_code", $signed(want.code), $signed(got.code));
      if (got.st !== want.st)         flag_field("status", want.st, got.st);
      if (got.flight !== want.flight) flag_field("in_flight", want.flight, got.flight);
      if (got.ferr !== want.ferr)
        flag_field("first_error", $signed(want.ferr), $signed(got.ferr));
      if (got.idle !== want.idle)     flag_field("all_done", want.idle, got.idle);
      if (got.last !== want.last)     flag_field("last", want.last, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t got;
    if (!rst_ni) begin
      due_results.delete();
      nxt_tag   = '0;
      head_tag  = '0;
      open_cnt  = 0;
      flight    = '0;
      done_m    = '0;
      err_latch = '0;
      limit     = MAX_IN_FLIGHT_RST;
      skip_nf   = 1'b0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{kind_i, out_tag_i, out_code_i, status_i, in_flight_i, first_error_i,
                all_done_i, last_i};
        check_result(got);
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_IGNORE_NOT_FOUND) begin
          skip_nf = pwdata[0];
        end else begin
          limit = cnt_t'(pwdata[4:0]);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        advance_window(req_e'(req_type_i), tag_i, ret_code_i);
      end
    end
    due_o    = due_results.size();
    head_o   = head_tag;
    open_o   = open_cnt;
    flight_o = flight;
    done_o   = done_m;
  end

endmodule

FILE: dv/tb_ordered_completion_throttle.sv
// Testbench top: drives items and register writes into the throttle and gives the verdict.
module tb_ordered_completion_throttle;
  timeunit 1ns;
  timeprecision 1ps;
  import oct_pkg::*;

  localparam int    WATCHDOG_LIMIT = 4000;
  localparam int    HOLD_CYCLES    = 300;
  localparam int    SETTLE_CYCLES  = 4;
  localparam int    TAIL_CYCLES    = 24;
  localparam int    N_PHASES       = 6;
  localparam int    PHASE_ITEMS    = 65;
  localparam int    PRESSURE_PHASE = 4;
  localparam code_t CODE_MIN       = code_t'(-4095);
  localparam code_t CODE_MAX       = code_t'(4095);

  localparam int PH_LIMIT  [N_PHASES] = '{31, 16, 1, 4, 16, 8};
  localparam int PH_IGNORE [N_PHASES] = '{0, 1, 0, 1, 0, 1};
  localparam int PH_TX     [N_PHASES] = '{0, 67, 0, 35, 0, 35};
  localparam int PH_RX     [N_PHASES] = '{0, 0, 67, 35, 0, 35};

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        req_type_i;
  tag_t              tag_i;
  code_t             ret_code_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              kind_o;
  tag_t              out_tag_o;
  code_t             out_code_o;
  logic [1:0]        status_o;
  cnt_t              in_flight_o;
  code_t             first_error_o;
  logic              all_done_o;
  logic              last_o;

  int                errors;
  int                checked;
  int                due;
  tag_t              win_head;
  int                win_open;
  cnt_t              win_flight;
  logic [WINDOW-1:0] win_done;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit hold_req     = 1'b0;
  int idle_cycles  = 0;
  int n_items      = 0;
  int n_settings   = 0;

  ordered_completion_throttle u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .tag_i         (tag_i),
    .ret_code_i    (ret_code_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .out_tag_o     (out_tag_o),
    .out_code_o    (out_code_o),
    .status_o      (status_o),
    .in_flight_o   (in_flight_o),
    .first_error_o (first_error_o),
    .all_done_o    (all_done_o),
    .last_o        (last_o)
  );

  oct_completion_monitor u_mon (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .req_type_i    (req_type_i),
    .tag_i         (tag_i),
    .ret_code_i    (ret_code_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_i        (kind_o),
    .out_tag_i     (out_tag_o),
    .out_code_i    (out_code_o),
    .status_i      (status_o),
    .in_flight_i   (in_flight_o),
    .first_error_i (first_error_o),
    .all_done_i    (all_done_o),
    .last_i        (last_o),
    .errors_o      (errors),
    .checked_o     (checked),
    .due_o         (due),
    .head_o        (win_head),
    .open_o        (win_open),
    .flight_o      (win_flight),
    .done_o        (win_done)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver side: random stalls, plus one long hold-off counted here on request.
  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  // Ends the run when no transfer and no register write happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic code_t pick_code();
    int v;
    case ($urandom_range(0, 9))
      0:       return CODE_MIN;
      1:       return CODE_MAX;
      2:       return NOT_FOUND_CODE;
      3:       return '0;
      4, 5:    v = int'($urandom_range(0, 20)) - 10;
      default: v = int'($urandom_range(0, 8190)) - 4095;
    endcase
    return code_t'(v);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(req_e rq, tag_t tg, code_t cd);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = rq;
    tag_i      = tg;
    ret_code_i = cd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic settle(int gap);
    in_valid_i = 1'b0;
    while (due != 0) @(negedge clk_i);
    repeat (gap) @(negedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Upper data bits are random; only the register's own bits should matter.
  task automatic apply_settings(cnt_t lim, logic ign);
    logic [31:0] w;
    settle(SETTLE_CYCLES);
    w      = $urandom;
    w[4:0] = lim;
    reg_write({REG_MAX_IN_FLIGHT, 2'b00}, w);
    w      = $urandom;
    w[0]   = ign;
    reg_write({REG_IGNORE_NOT_FOUND, 2'b00}, w);
    n_settings++;
  endtask

  // Empties the window, fills all of it, then finishes from the tail so that
  // the finish of the head releases the whole window at once.
  task automatic fill_and_drain();
    tag_t base;
    while (win_flight != 0) send_item(REQ_END, tag_t'($urandom), code_t'($urandom_range(0, 4095)));
    while (win_open != 0) send_item(REQ_FINISH, win_head, pick_code());
    while (win_open < WINDOW) send_item(REQ_START, tag_t'($urandom), pick_code());
    send_item(REQ_START, tag_t'($urandom), pick_code());
    base = win_head;
    for (int i = WINDOW - 1; i >= 0; i--) begin
      send_item(REQ_FINISH, base + tag_t'(i), pick_code());
    end
  endtask

  task automatic random_item();
    tag_t undone[$];
    tag_t tg;
    int   pick;
    for (int i = 0; i < win_open; i++) begin
      tg = win_head + tag_t'(i);
      if (!win_done[tg]) undone.push_back(tg);
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_item(req_e'($urandom_range(0, 3)), tag_t'($urandom), pick_code());
    end else if (pick < 45 && win_open > 0) begin
      // Mostly open entries; now and then a done one, whose code is overwritten.
      if (undone.size() > 0 && $urandom_range(0, 5) != 0) begin
        tg = undone[$urandom_range(0, undone.size() - 1)];
      end else begin
        tg = win_head + tag_t'($urandom_range(0, win_open - 1));
      end
      send_item(REQ_FINISH, tg, pick_code());
    end else if (pick < 72 || win_flight == 0) begin
      send_item(REQ_START, tag_t'($urandom), pick_code());
    end else begin
      send_item(REQ_END, tag_t'($urandom), pick_code());
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = REQ_NONE;
    tag_i      = '0;
    ret_code_i = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Limit of two, not-found codes skipped.
    apply_settings(cnt_t'(2), 1'b1);
    send_item(REQ_END, 4'hF, CODE_MIN);
    send_item(REQ_FINISH, 4'h0, '0);
    send_item(REQ_NONE, 4'hA, CODE_MAX);
    send_item(REQ_START, 4'h5, '0);
    send_item(REQ_START, 4'h0, '0);
    send_item(REQ_START, 4'hF, CODE_MAX);
    send_item(REQ_FINISH, 4'h1, CODE_MAX);
    send_item(REQ_FINISH, 4'h1, CODE_MIN);
    send_item(REQ_FINISH, 4'h0, code_t'(1));
    send_item(REQ_END, 4'h0, NOT_FOUND_CODE);
    send_item(REQ_END, 4'h0, code_t'(5));
    send_item(REQ_END, 4'h0, code_t'(-1));
    send_item(REQ_FINISH, 4'hF, CODE_MIN);

    // A zero limit refuses every start.
    apply_settings(cnt_t'(0), 1'b0);
    send_item(REQ_START, 4'h3, '0);
    send_item(REQ_END, 4'h3, CODE_MIN);

    // Limit above the window; the first error latched is the not-found code.
    apply_settings(cnt_t'(31), 1'b0);
    send_item(REQ_START, 4'h0, '0);
    send_item(REQ_END, 4'h0, NOT_FOUND_CODE);
    send_item(REQ_START, 4'h0, '0);
    send_item(REQ_END, 4'h0, CODE_MIN);
    fill_and_drain();

    for (int p = 0; p < N_PHASES; p++) begin
      apply_settings(cnt_t'(PH_LIMIT[p]), PH_IGNORE[p][0]);
      tx_idle_pct  = PH_TX[p];
      rx_stall_pct = PH_RX[p];
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        if (p == PRESSURE_PHASE && j == 5) hold_req = 1'b1;
        random_item();
      end
    end

    settle(TAIL_CYCLES);
    $display("Sent %0d items and checked %0d results over %0d register settings,",
             n_items, checked, n_settings);
    $display("with refused starts, unknown tags, a full window release and a long hold-off.");
    if (errors == 0 && due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/oct_pkg.sv
rtl/core/oct_window.sv
rtl/core/ordered_completion_throttle.sv
dv/oct_completion_monitor.sv
dv/tb_ordered_completion_throttle.sv
